FILE: rtl/mbrq_pkg.sv
// mbrq_pkg: beat types, command and scan-mode codes, default sizes for the
// mark bitmap range query block. No dependencies.
`default_nettype none

package mbrq_pkg;

   localparam int NUM_CELLS_DEF = 1024;
   localparam int CELL_BITS_DEF = 32;

   // cell counter: holds any cell number a bit index can name, and NUM_CELLS
   localparam int CELL_CNT_W = 17;
   localparam int DIVIDEND_W = 16;

   localparam logic [2:0] CMD_WRITE = 3'd0;
   localparam logic [2:0] CMD_RSET  = 3'd1;
   localparam logic [2:0] CMD_RCLR  = 3'd2;
   localparam logic [2:0] CMD_FIND  = 3'd3;
   localparam logic [2:0] CMD_CLEAN = 3'd4;

   localparam logic [2:0] MODE_RSET  = 3'd0;
   localparam logic [2:0] MODE_RCLR  = 3'd1;
   localparam logic [2:0] MODE_CLEAN = 3'd2;
   localparam logic [2:0] MODE_PROBE = 3'd3;
   localparam logic [2:0] MODE_NZ    = 3'd4;
   localparam logic [2:0] MODE_ONES  = 3'd5;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [9:0]  wr_index;
      logic [31:0] cell_value;
      logic [15:0] range_start;
      logic [15:0] range_end;
      logic [14:0] probe_bit;
   } req_type;

   typedef struct packed {
      logic        answer;
      logic [14:0] start_bit;
      logic        probe_was_marked;
   } rsp_type;

   typedef struct packed {
      logic        done;
      logic        answer;
      logic        marked;
      logic [14:0] start_bit;
      logic [2:0]  next_mode;
   } unit_out_type;

endpackage

`default_nettype wire

FILE: rtl/mbrq_mem.sv
// mbrq_mem: mark cell storage, one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module mbrq_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: rtl/mbrq_div.sv
// mbrq_div: splits a bit index into cell number and bit offset by shift and
// mask (cell width a power of two), result registered in the cycle after start. Uses mbrq_pkg.
`default_nettype none

module mbrq_div #(
   parameter int DIVISOR = mbrq_pkg::CELL_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [mbrq_pkg::DIVIDEND_W-1:0]     dividend,
   output logic                                     done,
   output logic      [mbrq_pkg::DIVIDEND_W-1:0]     quotient,
   output logic      [$clog2(DIVISOR)-1:0]          remainder
);
   import mbrq_pkg::*;

   localparam int RW = $clog2(DIVISOR);

   logic                  done_ff, done_in;
   logic [DIVIDEND_W-1:0] quo_ff,  quo_in;
   logic [RW-1:0]         rem_ff,  rem_in;

   always_comb begin
      done_in = start;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         quo_in = dividend >> RW;
         rem_in = dividend[RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

FILE: rtl/mbrq_cell_unit.sv
// mbrq_cell_unit: evaluates one mark cell for the active scan mode (range
// test, clean test, object start search). Depends on mbrq_pkg.
`default_nettype none

module mbrq_cell_unit #(
   parameter int CELL_BITS = mbrq_pkg::CELL_BITS_DEF
) (
   input  wire logic [2:0]                      mode,
   input  wire logic [CELL_BITS-1:0]            value,
   input  wire logic [mbrq_pkg::CELL_CNT_W-1:0] tag,
   input  wire logic                            is_first,
   input  wire logic                            is_last,
   input  wire logic [$clog2(CELL_BITS)-1:0]    lo_off,
   input  wire logic [$clog2(CELL_BITS)-1:0]    hi_off,
   output mbrq_pkg::unit_out_type               uo
);
   import mbrq_pkg::*;

   localparam int OW = $clog2(CELL_BITS);

   function automatic logic [OW-1:0] top_bit(input logic [CELL_BITS-1:0] v);
      logic [OW-1:0] h;
      h = '0;
      for (int i = 0; i < CELL_BITS; i++) begin
         if (v[i]) begin
            h = OW'(i);
         end
      end
      return h;
   endfunction

   logic [OW-1:0]        lo, hi, h, hw, ho;
   logic [CELL_BITS-1:0] span, pmask, vp, below, w;
   logic [14:0]          base;
   logic                 at_zero;

   always_comb begin
      lo = is_first ? lo_off : '0;
      hi = is_last ? hi_off : OW'(CELL_BITS - 1);
      for (int i = 0; i < CELL_BITS; i++) begin
         span[i]  = (OW'(i) >= lo) && (OW'(i) <= hi);
         pmask[i] = OW'(i) <= lo_off;
      end
      vp = (mode == MODE_PROBE) ? (value & pmask) : value;
      h  = top_bit(vp);
      for (int i = 0; i < CELL_BITS; i++) begin
         below[i] = OW'(i) < h;
      end
      w       = ~vp & below;
      hw      = top_bit(w);
      ho      = top_bit(~value);
      base    = 15'(tag * CELL_CNT_W'(CELL_BITS));
      at_zero = tag == '0;

      uo           = '0;
      uo.next_mode = mode;
      case (mode)
         MODE_RSET: begin
            if ((value & span) != span) begin
               uo.done = 1'b1;
            end else if (is_last) begin
               uo.done   = 1'b1;
               uo.answer = 1'b1;
            end
         end
         MODE_RCLR: begin
            if ((value & span) != '0) begin
               uo.done = 1'b1;
            end else if (is_last) begin
               uo.done   = 1'b1;
               uo.answer = 1'b1;
            end
         end
         MODE_CLEAN: begin
            if (value != '0) begin
               uo.done = 1'b1;
            end else if (is_last) begin
               uo.done   = 1'b1;
               uo.answer = 1'b1;
            end
         end
         MODE_PROBE, MODE_NZ: begin
            if (mode == MODE_PROBE && value[lo_off]) begin
               uo.done   = 1'b1;
               uo.marked = 1'b1;
            end else if (vp == '0) begin
               uo.next_mode = MODE_NZ;
               uo.done      = at_zero;
            end else if (w != '0) begin
               uo.done      = 1'b1;
               uo.start_bit = base + 15'(hw) + 15'd1;
            end else if (at_zero) begin
               uo.done = 1'b1;
            end else begin
               // run reaches bit 0 of this cell: keep going below
               uo.next_mode = MODE_ONES;
            end
         end
         MODE_ONES: begin
            if (value == '1) begin
               uo.done = at_zero;
            end else begin
               uo.done      = 1'b1;
               uo.start_bit = base + 15'(ho) + 15'd1;
            end
         end
         default: begin
            uo.done = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/mark_bitmap_range_query.sv
// mark_bitmap_range_query: top level, command sequencer and one-cell-per-cycle
// scan of the mark memory. Uses mbrq_pkg, mbrq_mem, mbrq_div, mbrq_cell_unit.
// A range query tests up to 2048 cells; a find start scans cells down from the
// probe cell; an is-clean tests up to NUM_CELLS cells. One command at a time.
// Reset: a clearing pass zeroes every one of the NUM_CELLS cells, req_stall high.
`default_nettype none

module mark_bitmap_range_query #(
   parameter int NUM_CELLS = mbrq_pkg::NUM_CELLS_DEF,
   parameter int CELL_BITS = mbrq_pkg::CELL_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mbrq_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output mbrq_pkg::rsp_type      rsp_data
);
   import mbrq_pkg::*;

   localparam int AW = $clog2(NUM_CELLS);
   localparam int OW = $clog2(CELL_BITS);
   localparam int CW = CELL_CNT_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_DIV1  = 3'd2;
   localparam logic [2:0] ST_DIV2  = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;
   localparam logic [2:0] ST_PUSH  = 3'd5;

   logic [2:0]      state_ff,    state_in;
   logic [AW-1:0]   clr_ff,      clr_in;
   logic [2:0]      cmd_ff,      cmd_in;
   logic [15:0]     e_ff,        e_in;
   logic [CW-1:0]   cur_ff,      cur_in;
   logic [CW-1:0]   first_ff,    first_in;
   logic [CW-1:0]   last_ff,     last_in;
   logic [CW-1:0]   tag_ff,      tag_in;
   logic            up_ff,       up_in;
   logic            iss_on_ff,   iss_on_in;
   logic            pend_ff,     pend_in;
   logic [2:0]      mode_ff,     mode_in;
   logic [OW-1:0]   lo_ff,       lo_in;
   logic [OW-1:0]   hi_ff,       hi_in;
   rsp_type         res_ff,      res_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic                  acc;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr, mem_raddr;
   logic [CELL_BITS-1:0]  mem_wdata, mem_rdata, cell_val;
   logic                  div_start, div_done;
   logic [DIVIDEND_W-1:0] div_dividend, div_quo;
   logic [OW-1:0]         div_rem;
   unit_out_type          uo;

   mbrq_mem #(.DEPTH(NUM_CELLS), .WIDTH(CELL_BITS)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   mbrq_div #(.DIVISOR(CELL_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // cells past the bitmap read as clear
   assign cell_val = (tag_ff >= CW'(NUM_CELLS)) ? '0 : mem_rdata;

   mbrq_cell_unit #(.CELL_BITS(CELL_BITS)) u_unit (
      .mode     (mode_ff),
      .value    (cell_val),
      .tag      (tag_ff),
      .is_first (tag_ff == first_ff),
      .is_last  (tag_ff == last_ff),
      .lo_off   (lo_ff),
      .hi_off   (hi_ff),
      .uo       (uo)
   );

   assign req_stall = state_ff != ST_IDLE;
   assign acc       = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      e_in         = e_ff;
      cur_in       = cur_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      tag_in       = tag_ff;
      up_in        = up_ff;
      iss_on_in    = iss_on_ff;
      pend_in      = pend_ff;
      mode_in      = mode_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = clr_ff;
      mem_wdata    = '0;
      mem_raddr    = AW'(cur_ff);
      div_start    = 1'b0;
      div_dividend = req_data.range_start;

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(NUM_CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (acc) begin
               cmd_in = req_data.cmd;
               res_in = '0;
               case (req_data.cmd)
                  CMD_WRITE: begin
                     if (CW'(req_data.wr_index) < CW'(NUM_CELLS)) begin
                        mem_we = 1'b1;
                     end
                     mem_waddr = AW'(req_data.wr_index);
                     mem_wdata = CELL_BITS'(req_data.cell_value);
                     state_in  = ST_PUSH;
                  end
                  CMD_RSET, CMD_RCLR: begin
                     if (req_data.range_start >= req_data.range_end) begin
                        res_in.answer = req_data.cmd == CMD_RCLR;
                        state_in      = ST_PUSH;
                     end else begin
                        div_start = 1'b1;
                        e_in      = req_data.range_end - 16'd1;
                        state_in  = ST_DIV1;
                     end
                  end
                  CMD_FIND: begin
                     div_start    = 1'b1;
                     div_dividend = {1'b0, req_data.probe_bit};
                     state_in     = ST_DIV1;
                  end
                  CMD_CLEAN: begin
                     cur_in    = '0;
                     first_in  = '0;
                     last_in   = CW'(NUM_CELLS - 1);
                     up_in     = 1'b1;
                     iss_on_in = 1'b1;
                     pend_in   = 1'b0;
                     mode_in   = MODE_CLEAN;
                     state_in  = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_PUSH;
                  end
               endcase
            end
         end
         ST_DIV1: begin
            if (div_done) begin
               first_in = CW'(div_quo);
               cur_in   = CW'(div_quo);
               lo_in    = div_rem;
               if (cmd_ff == CMD_FIND) begin
                  last_in   = '0;
                  up_in     = 1'b0;
                  mode_in   = MODE_PROBE;
                  iss_on_in = 1'b1;
                  pend_in   = 1'b0;
                  state_in  = ST_SCAN;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = e_ff;
                  mode_in      = (cmd_ff == CMD_RSET) ? MODE_RSET : MODE_RCLR;
                  state_in     = ST_DIV2;
               end
            end
         end
         ST_DIV2: begin
            if (div_done) begin
               last_in   = CW'(div_quo);
               hi_in     = div_rem;
               up_in     = 1'b1;
               iss_on_in = 1'b1;
               pend_in   = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (iss_on_ff) begin
               tag_in  = cur_ff;
               pend_in = 1'b1;
               cur_in  = up_ff ? cur_ff + CW'(1) : cur_ff - CW'(1);
               if (cur_ff == last_ff) begin
                  iss_on_in = 1'b0;
               end
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (uo.done) begin
                  res_in.answer           = uo.answer;
                  res_in.start_bit        = uo.start_bit;
                  res_in.probe_was_marked = uo.marked;
                  iss_on_in               = 1'b0;
                  pend_in                 = 1'b0;
                  state_in                = ST_PUSH;
               end else begin
                  mode_in = uo.next_mode;
               end
            end
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         iss_on_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         iss_on_ff    <= iss_on_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      e_ff        <= e_in;
      cur_ff      <= cur_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      tag_ff      <= tag_in;
      up_ff       <= up_in;
      mode_ff     <= mode_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == ST_SCAN)
      else $error("cell read pending outside scan");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && iss_on_ff && up_ff) |-> cur_ff <= last_ff)
      else $error("ascending scan cursor passed last cell");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV1 || state_ff == ST_DIV2))
      else $error("divider finished outside a divide state");

   a_rsp_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_PUSH)
      else $error("response beat raised without a finished command");

   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |=> (state_ff != ST_CLEAR))
      else $error("clearing pass re-entered without reset");

endmodule

`default_nettype wire

FILE: dv/mark_bitmap_range_query_tb.sv
// Self-checking testbench for mark_bitmap_range_query: a mark bitmap tracker
// predicts every response beat; directed corner cases, then random traffic.
// Depends on mbrq_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module mark_bitmap_range_query_tb;
   import mbrq_pkg::*;

   localparam int CELLS = NUM_CELLS_DEF;
   localparam int WBITS = CELL_BITS_DEF;
   localparam int MAP_BITS = CELLS * WBITS;
   localparam logic [WBITS-1:0] ALL = '1;

   class bitmap_tracker;
      logic [WBITS-1:0] cells [CELLS];
      rsp_type awaited [$];
      int errors;

      function new();
         foreach (cells[i]) cells[i] = '0;
         errors = 0;
      endfunction

      function logic [WBITS-1:0] cell_at(int unsigned c);
         return (c < CELLS) ? cells[c] : '0;
      endfunction

      function int unsigned top_bit(logic [WBITS-1:0] v);
         int unsigned h;
         h = 0;
         for (int i = 0; i < WBITS; i++) if (v[i]) h = i;
         return h;
      endfunction

      function bit range_holds(logic [15:0] s, logic [15:0] e, bit want_set);
         int unsigned sc, ec, lo, hi, last;
         logic [WBITS-1:0] m, v;
         if (s >= e) return !want_set;
         last = e - 1;
         sc = s / WBITS;
         ec = last / WBITS;
         for (int unsigned c = sc; c <= ec; c++) begin
            lo = (c == sc) ? s % WBITS : 0;
            hi = (c == ec) ? last % WBITS : WBITS - 1;
            m = (ALL >> (WBITS - 1 - hi)) & (ALL << lo);
            v = cell_at(c) & m;
            if (want_set ? (v != m) : (v != '0)) return 1'b0;
         end
         return 1'b1;
      endfunction

      // nearest run of set bits below the probe; lowest bit of that run
      function logic [14:0] object_start(logic [14:0] p, output bit marked);
         int unsigned c, pos, h, r;
         logic [WBITS-1:0] v, w;
         marked = 1'b0;
         c = p / WBITS;
         pos = p % WBITS;
         v = cell_at(c);
         if (v[pos]) begin
            marked = 1'b1;
            return '0;
         end
         v &= ALL >> (WBITS - 1 - pos);
         while (v == '0 && c > 0) begin
            c--;
            v = cell_at(c);
         end
         if (v == '0) return '0;
         h = top_bit(v);
         w = ~v & ((WBITS'(1) << h) - 1);
         if (w != '0) begin
            r = c * WBITS + top_bit(w) + 1;
         end else if (c == 0) begin
            r = 0;
         end else begin
            do begin
               c--;
               v = cell_at(c);
            end while (v == ALL && c > 0);
            r = (v == ALL) ? 0 : c * WBITS + top_bit(~v) + 1;
         end
         return r[14:0];
      endfunction

      function void note_cmd(req_type r);
         rsp_type x;
         bit mk;
         x = '0;
         case (r.cmd)
            CMD_WRITE: begin
               if (r.wr_index < CELLS) cells[r.wr_index] = r.cell_value;
            end
            CMD_RSET: x.answer = range_holds(r.range_start, r.range_end, 1'b1);
            CMD_RCLR: x.answer = range_holds(r.range_start, r.range_end, 1'b0);
            CMD_FIND: begin
               x.start_bit = object_start(r.probe_bit, mk);
               x.probe_was_marked = mk;
            end
            CMD_CLEAN: begin
               x.answer = 1'b1;
               foreach (cells[i]) if (cells[i] != '0) x.answer = 1'b0;
            end
            default: ;
         endcase
         awaited.push_back(x);
      endfunction

      function void check_rsp(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected beat, expected none got %h", $time, got);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.answer !== want.answer) begin
            $display("%0t: answer expected %0d got %0d", $time, want.answer, got.answer);
            errors++;
         end
         if (got.start_bit !== want.start_bit) begin
            $display("%0t: start_bit expected %0d got %0d", $time,
                     want.start_bit, got.start_bit);
            errors++;
         end
         if (got.probe_was_marked !== want.probe_was_marked) begin
            $display("%0t: probe_was_marked expected %0d got %0d", $time,
                     want.probe_was_marked, got.probe_was_marked);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int send_idle = 0;
   int recv_idle = 0;
   bitmap_tracker sb = new();

   mark_bitmap_range_query u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_rsp(rsp_data);
   end

   task automatic send_req(input req_type r);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sb.note_cmd(r);
      @(negedge clock);
   endtask

   function automatic req_type mk_req(logic [2:0] cmd, logic [9:0] idx, logic [31:0] val,
                                      logic [15:0] s, logic [15:0] e, logic [14:0] p);
      req_type r;
      r = '0;
      r.cmd = cmd;
      r.wr_index = idx;
      r.cell_value = val;
      r.range_start = s;
      r.range_end = e;
      r.probe_bit = p;
      return r;
   endfunction

   function automatic req_type noise_req();
      req_type r;
      r.cmd = 3'($urandom_range(7));
      r.wr_index = 10'($urandom_range(1023));
      r.cell_value = $urandom;
      r.range_start = 16'($urandom_range(65535));
      r.range_end = 16'($urandom_range(65535));
      r.probe_bit = 15'($urandom_range(32767));
      return r;
   endfunction

   function automatic logic [WBITS-1:0] cell_pattern();
      int unsigned lo, hi;
      logic [WBITS-1:0] m;
      lo = $urandom_range(WBITS - 1);
      hi = $urandom_range(WBITS - 1, lo);
      m = (ALL >> (WBITS - 1 - hi)) & (ALL << lo);
      case ($urandom_range(5))
         0: return ALL;
         1: return '0;
         2: return m;
         3: return ~m;
         default: return $urandom;
      endcase
   endfunction

   task automatic directed_cmds();
      req_type r;
      send_req(mk_req(CMD_CLEAN, 0, 0, 0, 0, 0));
      send_req(mk_req(CMD_FIND, 0, 0, 0, 0, 0));
      send_req(mk_req(CMD_FIND, 0, 0, 0, 0, 15'd32767));
      send_req(mk_req(CMD_RSET, 0, 0, 16'd5, 16'd5, 0));
      send_req(mk_req(CMD_RCLR, 0, 0, 16'd10, 16'd3, 0));
      send_req(mk_req(CMD_RCLR, 0, 0, 16'd0, 16'd32768, 0));
      send_req(mk_req(CMD_WRITE, 10'd0, ALL, 0, 0, 0));
      send_req(mk_req(CMD_WRITE, 10'd1023, 32'h8000_0001, 0, 0, 0));
      send_req(mk_req(CMD_WRITE, 10'd5, 32'h0000_f0f0, 0, 0, 0));
      send_req(mk_req(CMD_RSET, 0, 0, 16'd0, 16'd32, 0));
      send_req(mk_req(CMD_RSET, 0, 0, 16'd0, 16'd33, 0));
      send_req(mk_req(CMD_RCLR, 0, 0, 16'd32768, 16'd65535, 0));
      send_req(mk_req(CMD_RSET, 0, 0, 16'd32767, 16'd32768, 0));
      send_req(mk_req(CMD_RSET, 0, 0, 16'd32767, 16'd32769, 0));
      send_req(mk_req(CMD_RCLR, 0, 0, 16'd65535, 16'd65535, 0));
      send_req(mk_req(CMD_FIND, 0, 0, 0, 0, 15'd32767));
      send_req(mk_req(CMD_FIND, 0, 0, 0, 0, 15'd32766));
      send_req(mk_req(CMD_FIND, 0, 0, 0, 0, 15'd40));
      send_req(mk_req(CMD_FIND, 0, 0, 0, 0, 15'd170));
      send_req(mk_req(CMD_FIND, 0, 0, 0, 0, 15'd0));
      send_req(mk_req(CMD_CLEAN, 0, 0, 0, 0, 0));
      for (int u = CMD_CLEAN + 1; u <= 7; u++) begin
         r = noise_req();
         r.cmd = 3'(u);
         send_req(r);
      end
      send_req(mk_req(CMD_WRITE, 10'd1023, 32'h0, 16'hffff, 16'hffff, 15'h7fff));
   endtask

   // traffic concentrated on an 8-cell window so queries hit real data
   task automatic random_cmds(input int n, input int unsigned win);
      req_type r;
      int unsigned k, base, p;
      base = win * WBITS;
      for (int i = 0; i < n; i++) begin
         r = noise_req();
         k = $urandom_range(99);
         if (k < 30) begin
            r.cmd = CMD_WRITE;
            if ($urandom_range(4) != 0) r.wr_index = 10'(win + $urandom_range(7));
            r.cell_value = cell_pattern();
         end else if (k < 58) begin
            r.cmd = (k < 44) ? CMD_RSET : CMD_RCLR;
            if ($urandom_range(29) != 0) begin
               r.range_start = 16'(base + $urandom_range(320));
               r.range_end = ($urandom_range(9) == 0) ?
                             16'(r.range_start - $urandom_range(3)) :
                             16'(r.range_start + $urandom_range(72));
            end
         end else if (k < 88) begin
            r.cmd = CMD_FIND;
            if ($urandom_range(19) != 0) begin
               p = base + $urandom_range(400);
               r.probe_bit = 15'((p > MAP_BITS - 1) ? MAP_BITS - 1 : p);
            end
         end else if (k < 93) begin
            r.cmd = CMD_CLEAN;
         end else begin
            r.cmd = 3'($urandom_range(7, CMD_CLEAN + 1));
         end
         send_req(r);
      end
   endtask

   task automatic wipe_map();
      req_type r;
      for (int c = 0; c < CELLS; c++) begin
         if (sb.cells[c] != '0) begin
            r = noise_req();
            r.cmd = CMD_WRITE;
            r.wr_index = 10'(c);
            r.cell_value = '0;
            send_req(r);
         end
      end
      send_req(mk_req(CMD_CLEAN, 0, 0, 0, 0, 0));
   endtask

   initial begin
      int unsigned win;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 13 : (ph == 1) ? 75 : 0;
         recv_idle = (ph == 0) ? 75 : (ph == 1) ? 13 : 0;
         if (ph == 0) directed_cmds();
         win = (ph == 0) ? 0 : (ph == 1) ? CELLS - 8 : $urandom_range(CELLS - 8);
         random_cmds(185, win);
         wipe_map();
      end
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (2200) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #(60_000_000);
      $display("%0t: timeout, %0d beats still expected", $time, sb.awaited.size());
      $display("status: fail");
      $finish;
   end

endmodule
